/* design/bht_pkg.sv */
// Package for the bucket hash table engine: table geometry, operation,
// outcome and slot mark codes, and the controller/datapath command and status.
// No dependencies.
package bht_pkg;

   localparam int NUM_BUCKETS  = 8;
   localparam int BUCKET_SLOTS = 4;
   localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_SLOTS;
   localparam int SLOT_AW      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int CNT_W        = $clog2(TOTAL_SLOTS + 1);

   localparam int OP_W      = 2;
   localparam int KEY_W     = 31;
   localparam int OUTCOME_W = 2;
   localparam int RSP_SLOT_W = 5;
   localparam int MARK_W    = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUT_OK   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_MISS = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_DUP  = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_OVF  = 2'd3;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

   typedef struct packed {
      logic load;
      logic start;
      logic from_home;
      logic issue;
      logic wr_used;
      logic wr_gone;
   } bht_cmd_type;

   typedef struct packed {
      logic               rd_valid;
      logic               hit;
      logic               empty;
      logic               free;
      logic               last;
      logic [SLOT_AW-1:0] rd_addr;
   } bht_sts_type;

endpackage

/* design/bht_req_if.sv */
// Request channel interface: valid/ready handshake with op and key payload.
// Depends on bht_pkg.
interface bht_req_if;
   logic                     valid;
   logic                     ready;
   logic [bht_pkg::OP_W-1:0]  op;
   logic [bht_pkg::KEY_W-1:0] key;

   modport source (output valid, op, key, input ready);
   modport sink   (input valid, op, key, output ready);
endinterface

/* design/bht_rsp_if.sv */
// Response channel interface: valid/ready handshake with outcome and slot.
// Depends on bht_pkg.
interface bht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bht_pkg::OUTCOME_W-1:0]  outcome;
   logic [bht_pkg::RSP_SLOT_W-1:0] slot;

   modport source (output valid, outcome, slot, input ready);
   modport sink   (input valid, outcome, slot, output ready);
endinterface

/* design/bht_dp.sv */
// Datapath of the bucket hash table engine: key memory, slot marks, slot walker
// with registered read, and match/free/empty status. Depends on bht_pkg.
module bht_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bht_pkg::KEY_W-1:0] key_in,
   input  bht_pkg::bht_cmd_type      cmd,
   output bht_pkg::bht_sts_type      sts
);
   import bht_pkg::*;

   logic [KEY_W-1:0]   key_ff;
   logic [SLOT_AW-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [SLOT_AW-1:0] rd_addr_ff, rd_addr_in;
   logic               rd_last_ff, rd_last_in;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [MARK_W-1:0]  rd_mark_ff;
   logic [KEY_W-1:0]   home_key;
   logic [SLOT_AW-1:0] home_slot;

   logic [KEY_W-1:0]   key_mem [TOTAL_SLOTS];
   logic [MARK_W-1:0]  marks_ff [TOTAL_SLOTS];

   assign home_key  = cmd.load ? key_in : key_ff;
   assign home_slot = SLOT_AW'((home_key % NUM_BUCKETS) * BUCKET_SLOTS);

   always_comb begin
      addr_in     = addr_ff;
      cnt_in      = cnt_ff;
      rd_valid_in = 1'b0;
      rd_addr_in  = rd_addr_ff;
      rd_last_in  = rd_last_ff;
      if (cmd.start) begin
         addr_in = cmd.from_home ? home_slot : '0;
         cnt_in  = '0;
      end else if (cmd.issue && (cnt_ff != CNT_W'(TOTAL_SLOTS))) begin
         rd_valid_in = 1'b1;
         rd_addr_in  = addr_ff;
         rd_last_in  = (cnt_ff == CNT_W'(TOTAL_SLOTS - 1));
         addr_in     = (addr_ff == SLOT_AW'(TOTAL_SLOTS - 1)) ? '0 : addr_ff + 1'b1;
         cnt_in      = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_last_ff <= rd_last_in;
      if (cmd.load) begin
         key_ff <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_used) begin
         key_mem[rd_addr_ff] <= key_ff;
      end
      rd_key_ff <= key_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_SLOTS; i++) begin
            marks_ff[i] <= MARK_EMPTY;
         end
      end else if (cmd.wr_used) begin
         marks_ff[rd_addr_ff] <= MARK_USED;
      end else if (cmd.wr_gone) begin
         marks_ff[rd_addr_ff] <= MARK_GONE;
      end
   end

   always_ff @(posedge clock) begin
      rd_mark_ff <= marks_ff[addr_ff];
   end

   assign sts.rd_valid = rd_valid_ff;
   assign sts.hit      = (rd_mark_ff == MARK_USED) && (rd_key_ff == key_ff);
   assign sts.empty    = (rd_mark_ff == MARK_EMPTY);
   assign sts.free     = (rd_mark_ff != MARK_USED);
   assign sts.last     = rd_last_ff;
   assign sts.rd_addr  = rd_addr_ff;

   a_wr_on_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_used || cmd.wr_gone) |-> rd_valid_ff)
      else $error("slot write without a slot read in hand");
   a_fill_free: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_used |-> (rd_mark_ff != MARK_USED))
      else $error("insert overwrites an occupied slot");
   a_gone_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_gone |-> (rd_mark_ff == MARK_USED && rd_key_ff == key_ff))
      else $error("remove marks a slot that does not hold the key");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rd_last_ff) |=> !rd_valid_ff || $past(cmd.start))
      else $error("walk reads past the last slot");

endmodule

/* design/bht_ctrl.sv */
// Controller of the bucket hash table engine: operation sequencing over the
// duplicate scan and probe walks, and the registered response. Depends on
// bht_pkg, bht_req_if and bht_rsp_if.
module bht_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   bht_req_if.sink              req_if,
   bht_rsp_if.source            rsp_if,
   input  bht_pkg::bht_sts_type sts,
   output bht_pkg::bht_cmd_type cmd
);
   import bht_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      PROBE,
      FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [OUTCOME_W-1:0]  res_outcome_ff, res_outcome_in;
   logic [SLOT_AW-1:0]    res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_load;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      cmd            = '0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_if.valid) begin
               cmd.load = 1'b1;
               op_in    = req_if.op;
               case (req_if.op) inside
                  OP_INSERT: begin
                     cmd.start = 1'b1;
                     state_in  = SCAN;
                  end
                  OP_REMOVE, OP_SEARCH: begin
                     cmd.start     = 1'b1;
                     cmd.from_home = 1'b1;
                     state_in      = PROBE;
                  end
                  default: begin
                     res_outcome_in = OUT_MISS;
                     res_slot_in    = '0;
                     state_in       = FINISH;
                  end
               endcase
            end
         end
         SCAN: begin
            cmd.issue = 1'b1;
            if (sts.rd_valid) begin
               if (sts.hit) begin
                  res_outcome_in = OUT_DUP;
                  res_slot_in    = '0;
                  state_in       = FINISH;
               end else if (sts.last) begin
                  cmd.start     = 1'b1;
                  cmd.from_home = 1'b1;
                  state_in      = PROBE;
               end
            end
         end
         PROBE: begin
            cmd.issue = 1'b1;
            if (sts.rd_valid) begin
               if (op_ff == OP_INSERT) begin
                  if (sts.free) begin
                     cmd.wr_used    = 1'b1;
                     res_outcome_in = OUT_OK;
                     res_slot_in    = sts.rd_addr;
                     state_in       = FINISH;
                  end else if (sts.last) begin
                     res_outcome_in = OUT_OVF;
                     res_slot_in    = '0;
                     state_in       = FINISH;
                  end
               end else begin
                  if (sts.hit) begin
                     cmd.wr_gone    = (op_ff == OP_REMOVE);
                     res_outcome_in = OUT_OK;
                     res_slot_in    = sts.rd_addr;
                     state_in       = FINISH;
                  end else if (sts.empty || sts.last) begin
                     res_outcome_in = OUT_MISS;
                     res_slot_in    = '0;
                     state_in       = FINISH;
                  end
               end
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      rsp_outcome_in = rsp_load ? res_outcome_ff : rsp_outcome_ff;
      rsp_slot_in    = rsp_load ? RSP_SLOT_W'(res_slot_ff) : rsp_slot_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign req_if.ready   = (state_ff == IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.outcome = rsp_outcome_ff;
   assign rsp_if.slot    = rsp_slot_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response register overwritten before it was taken");
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while another transaction is in work");
   a_ok_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH && res_outcome_ff != OUT_OK) |-> (res_slot_ff == '0))
      else $error("failed outcome carries a nonzero slot");

endmodule

/* design/bucket_hash_table_engine.sv */
// Bucket hash table engine: insert, remove or search of one 31-bit key per
// transaction in a table of NUM_BUCKETS x BUCKET_SLOTS slots, probed linearly
// from the first slot of bucket key mod NUM_BUCKETS, wrapping over the table.
// One transaction is in work at a time; the slot walk does one key-memory
// read per cycle with registered read data; an insert first does a full
// 32-slot duplicate scan and then its probe. op 3 answers "not found"
// without a walk. A finished response waits in an output register while
// the next request is accepted. Slot marks clear at reset.
// Depends on bht_pkg, bht_req_if, bht_rsp_if, bht_ctrl and bht_dp.
module bucket_hash_table_engine (
   input  logic      clock,
   input  logic      reset,
   bht_req_if.sink   req_if,
   bht_rsp_if.source rsp_if
);
   import bht_pkg::*;

   bht_cmd_type cmd;
   bht_sts_type sts;

   bht_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .sts    (sts),
      .cmd    (cmd)
   );

   bht_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .key_in (req_if.key),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule
